### rtl/dde_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the decimal64 DPD encoder.
package dde_pkg;

  localparam int unsigned SigWidth     = 64;
  localparam int unsigned ExpWidth     = 10;
  localparam int unsigned WordWidth    = 64;
  localparam int unsigned DigitWidth   = 4;
  localparam int unsigned GroupWidth   = 3 * DigitWidth;
  localparam int unsigned DecletWidth  = 10;
  localparam int unsigned NumDeclets   = 5;
  localparam int unsigned CombWidth    = 5;
  localparam int unsigned ContWidth    = 8;

  // Exponent bias, in 11-bit signed arithmetic.
  localparam logic signed [ExpWidth:0] ExpBias = 11'sd398;

  // Combination field, exponent continuation and range flag.
  typedef struct packed {
    logic [CombWidth-1:0] comb;
    logic [ContWidth-1:0] cont;
    logic                 oor;
  } head_t;

endpackage

### rtl/dde_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the decimal64 DPD encoder.
interface dde_in_if
  import dde_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       sign;
  logic [SigWidth-1:0]        significand_bcd;
  logic signed [ExpWidth-1:0] exponent;

  modport source (output valid, sign, significand_bcd, exponent, input ready);
  modport sink   (input valid, sign, significand_bcd, exponent, output ready);
endinterface

interface dde_out_if
  import dde_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] encoded;
  logic                 exponent_out_of_range;

  modport source (output valid, encoded, exponent_out_of_range, input ready);
  modport sink   (input valid, encoded, exponent_out_of_range, output ready);
endinterface

### rtl/dde_declet.sv
`timescale 1ns / 1ps
// Packs three BCD digits into one 10-bit DPD declet.
module dde_declet
  import dde_pkg::*;
(
  input  logic [GroupWidth-1:0]  bcd_i,
  output logic [DecletWidth-1:0] declet_o
);

  logic [DigitWidth-1:0]  lo, mid, hi;
  logic [2:0]             lo_v, mid_v, hi_v;
  logic [2:0]             big;
  logic [DecletWidth-1:0] base, lo_top, mid_top;

  assign lo  = bcd_i[DigitWidth-1:0];
  assign mid = bcd_i[2*DigitWidth-1:DigitWidth];
  assign hi  = bcd_i[3*DigitWidth-1:2*DigitWidth];

  // Large digits (8..15) keep only their low bit.
  assign lo_v  = lo[3]  ? {2'b00, lo[0]}  : lo[2:0];
  assign mid_v = mid[3] ? {2'b00, mid[0]} : mid[2:0];
  assign hi_v  = hi[3]  ? {2'b00, hi[0]}  : hi[2:0];

  assign big     = {hi[3], mid[3], lo[3]};
  assign base    = {hi_v, mid_v, 1'b0, lo_v};
  assign lo_top  = {7'd0, lo_v[2:1], 1'b0};
  assign mid_top = {7'd0, mid_v[2:1], 1'b0};

  always_comb begin
    unique case (big)
      3'd0:    declet_o = base;
      3'd1:    declet_o = base | 10'h008;
      3'd2:    declet_o = (base & ~10'h00e) | 10'h00a | (lo_top << 4);
      3'd3:    declet_o = base | 10'h040 | 10'h00e;
      3'd4:    declet_o = (base & ~10'h00e) | 10'h00c | (lo_top << 7);
      3'd5:    declet_o = (base & ~10'h060) | (mid_top << 7) | 10'h020 | 10'h00e;
      3'd6:    declet_o = (base & ~10'h00e) | (lo_top << 7) | 10'h00e;
      default: declet_o = base | 10'h060 | 10'h00e;
    endcase
  end

endmodule

### rtl/dde_head.sv
`timescale 1ns / 1ps
// Biases the exponent and builds the combination field.
module dde_head
  import dde_pkg::*;
(
  input  logic                       lead_big_i,
  input  logic signed [ExpWidth-1:0] exp_i,
  input  logic [DigitWidth-1:0]      lead_i,
  output head_t                      head_o
);

  logic signed [ExpWidth:0] biased;

  // lead_big_i: leading digit is 8..15, selects the short form.
  assign biased = {exp_i[ExpWidth-1], exp_i} + ExpBias;

  always_comb begin
    head_o.cont = biased[ContWidth-1:0];
    // Negative, or at or above 768.
    head_o.oor  = biased[ExpWidth] | (biased[ExpWidth-1] & biased[ExpWidth-2]);
    if (lead_big_i) begin
      head_o.comb = {2'b11, biased[ExpWidth-1:ExpWidth-2], lead_i[0]};
    end else begin
      head_o.comb = {biased[ExpWidth-1:ExpWidth-2], lead_i[2:0]};
    end
  end

endmodule

### rtl/decimal64_dpd_encode_unit.sv
`timescale 1ns / 1ps
// Top level of the decimal64 DPD encoder: input register, recode, result register.
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    sign, significand_bcd, exponent
//   out_o    out  valid / ready    encoded, exponent_out_of_range
//
// One transaction in, one transaction out. Data passes through the input
// register, then the result register; the recode between them is pure logic.
// Sustained rate is one transaction per cycle while out_o is ready; each stage
// refills in the cycle it drains; an empty input stage loads under a held result.
// Reset clears both valid flags; payload registers are not reset.
// A stall on out_o backs up through ready with no loss or duplication.
module decimal64_dpd_encode_unit
  import dde_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  dde_in_if.sink   in_i,
  dde_out_if.source out_o
);

  // Input stage.
  logic                       s1_valid_q;
  logic                       s1_sign_q;
  logic [SigWidth-1:0]        s1_sig_q;
  logic signed [ExpWidth-1:0] s1_exp_q;

  // Result stage.
  logic                       out_valid_q;
  logic [WordWidth-1:0]       out_word_q;
  logic                       out_oor_q;

  logic                       out_free;
  logic                       s1_free;
  logic [NumDeclets*DecletWidth-1:0] declets;
  logic [DigitWidth-1:0]      lead;
  head_t                      head;
  logic [WordWidth-1:0]       word_d;

  // Result register can load when empty or being taken this cycle.
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_free  = !s1_valid_q || out_free;
  assign in_i.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_i.valid) begin
      s1_sign_q <= in_i.sign;
      s1_sig_q  <= in_i.significand_bcd;
      s1_exp_q  <= in_i.exponent;
    end
  end

  // Five declets from the low fifteen digits, lowest digits lowest.
  for (genvar g = 0; g < NumDeclets; g++) begin : g_declet
    dde_declet u_declet (
      .bcd_i    (s1_sig_q[g*GroupWidth +: GroupWidth]),
      .declet_o (declets[g*DecletWidth +: DecletWidth])
    );
  end

  assign lead = s1_sig_q[SigWidth-1 -: DigitWidth];

  dde_head u_head (
    .lead_big_i (lead[DigitWidth-1]),
    .exp_i      (s1_exp_q),
    .lead_i     (lead),
    .head_o     (head)
  );

  // sign | combination | exponent continuation | declets
  assign word_d = {s1_sign_q, head.comb, head.cont, declets};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_word_q <= word_d;
      out_oor_q  <= head.oor;
    end
  end

  assign out_o.valid                 = out_valid_q;
  assign out_o.encoded               = out_word_q;
  assign out_o.exponent_out_of_range = out_oor_q;

endmodule
